// ----- rtl/core/plane_contact_friction_core_assert.svh -----
// Assertion macros shared by the plane contact friction core.
`ifndef PLANE_CONTACT_FRICTION_CORE_ASSERT_SVH
`define PLANE_CONTACT_FRICTION_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge.
`define PCF_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, checked at every rising clock edge.
`define PCF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- rtl/core/pcf_pkg.sv -----
// Types, register indexes and helper functions of the plane contact friction core.
package pcf_pkg;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_STATIC_FRICTION  = 2'd0,
      CSR_KINETIC_FRICTION = 2'd1,
      CSR_FLOOR_HEIGHT     = 2'd2,
      CSR_WALL_POSITION    = 2'd3
   } pcf_csr_type;

   localparam logic [15:0] StaticFrictionReset  = 16'd39322;
   localparam logic [15:0] KineticFrictionReset = 16'd32768;
   localparam logic [31:0] FloorHeightReset     = 32'hFFFF_0000;
   localparam logic [31:0] WallPositionReset    = 32'h0001_0000;

   // Axis slots inside a plane unit: normal, first and second tangent.
   localparam int AxN = 0;
   localparam int AxA = 1;
   localparam int AxB = 2;

   typedef struct packed {
      logic [2:0][31:0] p;
      logic [2:0][31:0] c;
      logic [2:0][31:0] q;
      logic             last;
      logic             prior_hit;
      logic             hit;
   } pcf_item_type;

   function automatic logic [33:0] sx34(input logic [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   function automatic logic [32:0] mag34(input logic [33:0] v);
      logic [33:0] n;
      n = 34'd0 - v;
      return v[33] ? n[32:0] : v[32:0];
   endfunction

   // Clamp a 35 bit two's complement value to the signed 32 bit range.
   function automatic logic [31:0] sat35(input logic [34:0] v);
      logic [31:0] r;
      if (!v[34] && (v[33:31] != 3'b000)) begin
         r = 32'h7FFF_FFFF;
      end else if (v[34] && (v[33:31] != 3'b111)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/pcf_if.sv -----
// Valid/ready channel interfaces for particle requests and correction responses.
interface pcf_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] pred_x;
   logic signed [31:0] pred_y;
   logic signed [31:0] pred_z;
   logic signed [31:0] corr_in_x;
   logic signed [31:0] corr_in_y;
   logic signed [31:0] corr_in_z;
   logic signed [31:0] prev_x;
   logic signed [31:0] prev_y;
   logic signed [31:0] prev_z;
   logic              last_in;

   modport source (output valid, pred_x, pred_y, pred_z, corr_in_x, corr_in_y, corr_in_z,
                   prev_x, prev_y, prev_z, last_in, input ready);
   modport sink (input valid, pred_x, pred_y, pred_z, corr_in_x, corr_in_y, corr_in_z,
                 prev_x, prev_y, prev_z, last_in, output ready);
endinterface

interface pcf_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] corr_out_x;
   logic signed [31:0] corr_out_y;
   logic signed [31:0] corr_out_z;
   logic              floor_hit;
   logic              wall_hit;
   logic              last_out;

   modport source (output valid, corr_out_x, corr_out_y, corr_out_z, floor_hit, wall_hit,
                   last_out, input ready);
   modport sink (input valid, corr_out_x, corr_out_y, corr_out_z, floor_hit, wall_hit,
                 last_out, output ready);
endinterface

// ----- rtl/core/plane_contact_friction_core.sv -----
// Plane contact friction core: floor then wall contact with Coulomb friction per particle.
//
// Each request item carries one particle (predicted position, incoming correction and
// previous position, all signed Q15.16) and yields exactly one response item with the new
// correction. The floor contact (normal +y at floor_height) is applied first, then the wall
// contact (normal -x at wall_position). The core accepts one item every clock cycle unless
// the response side stalls. Each plane unit is 56 stages deep, set mostly by its 34-stage
// square root (one bit of the tangential length per stage) and its 16-stage restoring
// divider for the kinetic scale, and one output register follows the wall unit.
// A response that is not taken holds the whole pipeline in place, so req_ch.ready falls
// while rsp_ch.valid is high and rsp_ch.ready is low; nothing is lost or repeated.
// Configuration is written through csr_we/csr_index/csr_wdata and must only change while
// no item is in flight.
module plane_contact_friction_core (
   input  logic        clock,
   input  logic        reset,
   pcf_req_if.sink     req_ch,
   pcf_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pcf_pkg::*;

   `include "plane_contact_friction_core_assert.svh"

   // Configuration registers.
   logic [15:0] mu_s_ff, mu_k_ff;
   logic [31:0] floor_ff, wall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_s_ff  <= StaticFrictionReset;
         mu_k_ff  <= KineticFrictionReset;
         floor_ff <= FloorHeightReset;
         wall_ff  <= WallPositionReset;
      end else if (csr_we) begin
         case (pcf_csr_type'(csr_index))
            CSR_STATIC_FRICTION:  mu_s_ff  <= csr_wdata[15:0];
            CSR_KINETIC_FRICTION: mu_k_ff  <= csr_wdata[15:0];
            CSR_FLOOR_HEIGHT:     floor_ff <= csr_wdata;
            CSR_WALL_POSITION:    wall_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together whenever the output register can take a new item.
   logic         adv;
   logic         rsp_vld_ff;
   pcf_item_type rsp_item_ff;

   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // The floor unit sees y as its normal axis and x, z as tangents.
   pcf_item_type floor_in, floor_out, wall_in, wall_out;
   logic         floor_out_vld, wall_out_vld;

   always_comb begin
      floor_in.p[AxN]  = req_ch.pred_y;
      floor_in.p[AxA]  = req_ch.pred_x;
      floor_in.p[AxB]  = req_ch.pred_z;
      floor_in.c[AxN]  = req_ch.corr_in_y;
      floor_in.c[AxA]  = req_ch.corr_in_x;
      floor_in.c[AxB]  = req_ch.corr_in_z;
      floor_in.q[AxN]  = req_ch.prev_y;
      floor_in.q[AxA]  = req_ch.prev_x;
      floor_in.q[AxB]  = req_ch.prev_z;
      floor_in.last      = req_ch.last_in;
      floor_in.prior_hit = 1'b0;
      floor_in.hit       = 1'b0;
   end

   pcf_plane u_floor (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (req_ch.valid && adv),
      .in_item   (floor_in),
      .mu_s      (mu_s_ff),
      .mu_k      (mu_k_ff),
      .plane_pos (floor_ff),
      .flip      (1'b0),
      .out_vld   (floor_out_vld),
      .out_item  (floor_out)
   );

   // The wall unit sees x as its normal axis and y, z as tangents; the floor's x and y
   // slots swap places on the way in.
   always_comb begin
      wall_in.p[AxN] = floor_out.p[AxA];
      wall_in.p[AxA] = floor_out.p[AxN];
      wall_in.p[AxB] = floor_out.p[AxB];
      wall_in.c[AxN] = floor_out.c[AxA];
      wall_in.c[AxA] = floor_out.c[AxN];
      wall_in.c[AxB] = floor_out.c[AxB];
      wall_in.q[AxN] = floor_out.q[AxA];
      wall_in.q[AxA] = floor_out.q[AxN];
      wall_in.q[AxB] = floor_out.q[AxB];
      wall_in.last      = floor_out.last;
      wall_in.prior_hit = floor_out.hit;
      wall_in.hit       = 1'b0;
   end

   pcf_plane u_wall (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (floor_out_vld),
      .in_item   (wall_in),
      .mu_s      (mu_s_ff),
      .mu_k      (mu_k_ff),
      .plane_pos (wall_ff),
      .flip      (1'b1),
      .out_vld   (wall_out_vld),
      .out_item  (wall_out)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= wall_out_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_item_ff <= wall_out;
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.corr_out_x = rsp_item_ff.c[AxN];
   assign rsp_ch.corr_out_y = rsp_item_ff.c[AxA];
   assign rsp_ch.corr_out_z = rsp_item_ff.c[AxB];
   assign rsp_ch.floor_hit  = rsp_item_ff.prior_hit;
   assign rsp_ch.wall_hit   = rsp_item_ff.hit;
   assign rsp_ch.last_out   = rsp_item_ff.last;

   // A stall freezes the occupancy of both plane units.
   `PCF_ASSERT_NEXT(a_stall_freezes, clock, reset, !adv,
                    $stable(floor_out_vld) && $stable(wall_out_vld))
   // Reset leaves no result pending.
   `PCF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_vld_ff)

endmodule

// ----- rtl/core/pcf_plane.sv -----
// One planar contact with Coulomb friction as a stalling pipeline.
module pcf_plane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  pcf_pkg::pcf_item_type in_item,
   input  logic [15:0]           mu_s,
   input  logic [15:0]           mu_k,
   input  logic [31:0]           plane_pos,
   input  logic                  flip,
   output logic                  out_vld,
   output pcf_pkg::pcf_item_type out_item
);
   import pcf_pkg::*;

   localparam int RootW  = 34;
   localparam int RadW   = 2 * RootW;
   localparam int RemW   = RootW + 4;
   localparam int ScaleW = 16;
   localparam int ProdW  = 48;
   localparam int LenQW  = RootW + ScaleW;

   typedef struct packed {
      pcf_item_type       item;
      logic [33:0]        cn;
      logic [33:0]        ta;
      logic [33:0]        tb;
      logic [32:0]        ma;
      logic [32:0]        mb;
      logic [ProdW-1:0]   ks;
      logic [ProdW-1:0]   kk;
   } ctx_type;

   // Stage 1: depth, normal push and tangential displacement.
   logic [32:0] dw;
   logic [33:0] cn1, ta1, tb1;
   ctx_type     s1_in;
   ctx_type     s1_ctx_ff;
   logic [31:0] s1_d_ff;
   logic        s1_vld_ff;

   always_comb begin
      dw = flip ? ({in_item.p[AxN][31], in_item.p[AxN]} - {plane_pos[31], plane_pos})
                : ({plane_pos[31], plane_pos} - {in_item.p[AxN][31], in_item.p[AxN]});
      cn1 = flip ? (sx34(in_item.c[AxN]) - {2'b00, dw[31:0]})
                 : (sx34(in_item.c[AxN]) + {2'b00, dw[31:0]});
      ta1 = sx34(in_item.p[AxA]) + sx34(in_item.c[AxA]) - sx34(in_item.q[AxA]);
      tb1 = sx34(in_item.p[AxB]) + sx34(in_item.c[AxB]) - sx34(in_item.q[AxB]);
      s1_in          = '0;
      s1_in.item     = in_item;
      s1_in.item.hit = !dw[32] && (dw[31:0] != 32'd0);
      s1_in.cn       = cn1;
      s1_in.ta       = ta1;
      s1_in.tb       = tb1;
      s1_in.ma       = mag34(ta1);
      s1_in.mb       = mag34(tb1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctx_ff <= s1_in;
         s1_d_ff   <= dw[31:0];
      end
   end

   // Stage 2: squares of the tangential magnitudes and friction bounds.
   ctx_type     s2_in;
   ctx_type     s2_ctx_ff;
   logic [65:0] s2_sqa_ff, s2_sqb_ff;
   logic        s2_vld_ff;

   always_comb begin
      s2_in    = s1_ctx_ff;
      s2_in.ks = ProdW'(mu_s) * ProdW'(s1_d_ff);
      s2_in.kk = ProdW'(mu_k) * ProdW'(s1_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctx_ff <= s2_in;
         s2_sqa_ff <= 66'(s1_ctx_ff.ma) * 66'(s1_ctx_ff.ma);
         s2_sqb_ff <= 66'(s1_ctx_ff.mb) * 66'(s1_ctx_ff.mb);
      end
   end

   // Square root, one result bit per stage.
   ctx_type          sq_ctx_ff  [RootW+1];
   logic [RadW-1:0]  sq_rad_ff  [RootW+1];
   logic [RemW-1:0]  sq_rem_ff  [RootW+1];
   logic [RootW-1:0] sq_root_ff [RootW+1];
   logic             sq_vld_ff  [RootW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ctx_ff[0]  <= s2_ctx_ff;
         sq_rad_ff[0]  <= {1'b0, 67'(s2_sqa_ff) + 67'(s2_sqb_ff)};
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < RootW; k++) begin : g_sqrt
      logic [RemW-1:0] rem_sh, trial;
      assign rem_sh = {sq_rem_ff[k][RemW-3:0], sq_rad_ff[k][RadW-1-2*k -: 2]};
      assign trial  = {{(RemW-RootW-2){1'b0}}, sq_root_ff[k], 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ctx_ff[k+1] <= sq_ctx_ff[k];
            sq_rad_ff[k+1] <= sq_rad_ff[k];
            if (rem_sh >= trial) begin
               sq_rem_ff[k+1]  <= rem_sh - trial;
               sq_root_ff[k+1] <= {sq_root_ff[k][RootW-2:0], 1'b1};
            end else begin
               sq_rem_ff[k+1]  <= rem_sh;
               sq_root_ff[k+1] <= {sq_root_ff[k][RootW-2:0], 1'b0};
            end
         end
      end
   end

   // Static/kinetic decision, then the kinetic scale by restoring division.
   ctx_type           dv_ctx_ff  [ScaleW+1];
   logic [RootW-1:0]  dv_len_ff  [ScaleW+1];
   logic              dv_full_ff [ScaleW+1];
   logic [ProdW-1:0]  dv_rem_ff  [ScaleW+1];
   logic [ScaleW-1:0] dv_q_ff    [ScaleW+1];
   logic              dv_vld_ff  [ScaleW+1];
   logic [LenQW-1:0]  lq;
   ctx_type           sq_last;

   assign sq_last = sq_ctx_ff[RootW];
   assign lq      = {sq_root_ff[RootW], {ScaleW{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= sq_vld_ff[RootW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ctx_ff[0]  <= sq_last;
         dv_len_ff[0]  <= sq_root_ff[RootW];
         dv_full_ff[0] <= (LenQW'(sq_last.ks) > lq) || (LenQW'(sq_last.kk) >= lq);
         dv_rem_ff[0]  <= sq_last.kk;
         dv_q_ff[0]    <= '0;
      end
   end

   for (genvar k = 0; k < ScaleW; k++) begin : g_div
      logic [LenQW-1:0] sub;
      logic             take;
      assign sub  = LenQW'(dv_len_ff[k]) << (ScaleW - 1 - k);
      assign take = LenQW'(dv_rem_ff[k]) >= sub;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ctx_ff[k+1]  <= dv_ctx_ff[k];
            dv_len_ff[k+1]  <= dv_len_ff[k];
            dv_full_ff[k+1] <= dv_full_ff[k];
            dv_rem_ff[k+1]  <= take ? (dv_rem_ff[k] - sub[ProdW-1:0]) : dv_rem_ff[k];
            dv_q_ff[k+1]    <= {dv_q_ff[k][ScaleW-2:0], take};
         end
      end
   end

   // Scale the tangential magnitudes.
   ctx_type     m_ctx_ff;
   logic        m_full_ff;
   logic [48:0] m_pa_ff, m_pb_ff;
   logic        m_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= dv_vld_ff[ScaleW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ctx_ff  <= dv_ctx_ff[ScaleW];
         m_full_ff <= dv_full_ff[ScaleW];
         m_pa_ff   <= 49'(dv_ctx_ff[ScaleW].ma) * 49'(dv_q_ff[ScaleW]);
         m_pb_ff   <= 49'(dv_ctx_ff[ScaleW].mb) * 49'(dv_q_ff[ScaleW]);
      end
   end

   // Final stage: remove the friction share and saturate.
   logic [33:0]  sa, sb, ra, rb;
   logic [34:0]  ca2, cb2;
   pcf_item_type f_in;
   pcf_item_type f_item_ff;
   logic         f_vld_ff;

   always_comb begin
      sa  = {1'b0, m_pa_ff[48:16]};
      sb  = {1'b0, m_pb_ff[48:16]};
      ra  = m_full_ff ? m_ctx_ff.ta : (m_ctx_ff.ta[33] ? (34'd0 - sa) : sa);
      rb  = m_full_ff ? m_ctx_ff.tb : (m_ctx_ff.tb[33] ? (34'd0 - sb) : sb);
      ca2 = {{3{m_ctx_ff.item.c[AxA][31]}}, m_ctx_ff.item.c[AxA]} - {ra[33], ra};
      cb2 = {{3{m_ctx_ff.item.c[AxB][31]}}, m_ctx_ff.item.c[AxB]} - {rb[33], rb};
      f_in = m_ctx_ff.item;
      if (m_ctx_ff.item.hit) begin
         f_in.c[AxN] = sat35({m_ctx_ff.cn[33], m_ctx_ff.cn});
         f_in.c[AxA] = sat35(ca2);
         f_in.c[AxB] = sat35(cb2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_item_ff <= f_in;
      end
   end

   assign out_vld  = f_vld_ff;
   assign out_item = f_item_ff;

endmodule
